[hdl/keg_pkg.sv]
// ----------------------------------------------------------------------------
// keg_pkg
// Types and constants shared by the key event generator.
// ----------------------------------------------------------------------------
`default_nettype none

package keg_pkg;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_READ = 2'd1,
		OP_FUNC = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		KIND_NONE     = 3'd0,
		KIND_TOUCH    = 3'd1,
		KIND_PRESSED  = 3'd2,
		KIND_LONG     = 3'd3,
		KIND_REPEAT   = 3'd4,
		KIND_RELEASED = 3'd5,
		KIND_FIRST    = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		REG_PRESS   = 2'd0,
		REG_LONG    = 2'd1,
		REG_REPEAT  = 2'd2,
		REG_RELEASE = 2'd3
	} reg_idx_t;

	localparam int unsigned KEY_W = 3;
	localparam int unsigned CNT_W = 8;

	localparam logic [CNT_W-1:0] HOLD_LOCKED = 8'hFF;
	localparam logic [CNT_W-1:0] HOLD_MAX    = 8'd254;
	localparam logic [CNT_W-1:0] REL_MAX     = 8'd255;

	localparam logic [CNT_W-1:0] PRESS_RST   = 8'd4;
	localparam logic [CNT_W-1:0] LONG_RST    = 8'd100;
	localparam logic [CNT_W-1:0] REPEAT_RST  = 8'd110;
	localparam logic [CNT_W-1:0] RELEASE_RST = 8'd4;

	typedef struct packed {
		kind_t             kind;
		logic [KEY_W-1:0]  keys;
		logic              posted;
		logic              scan;
	} result_t;

endpackage

`default_nettype wire

[hdl/key_event_generator.sv]
// ----------------------------------------------------------------------------
// key_event_generator
// Turns periodic key samples into touch/pressed/long/repeat/released events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one item per transfer: a
//   sampling tick with the key levels, a read-and-clear of the event slot, or
//   a function-change notice that locks the generator until all keys are up.
//   Every input item yields exactly one result on the output channel
//   (out_valid/out_stall): event kind, key set, a posted flag and scan_active,
//   which tells the timer whether more ticks are needed.
//   The result is registered at the input transfer into the output register,
//   or into the skid entry while a result waits there. One item per cycle is
//   accepted while the output flows. Behind the output register sits one
//   skid entry, so an item is still taken while a result waits; in_stall
//   rises only once both are full.
//   Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once and
//   are meant to happen while the block is idle.
//   Reset clears all counters, the key set and the event slot, and loads the
//   default timing registers.
// ----------------------------------------------------------------------------
`default_nettype none

module key_event_generator #(
	parameter int unsigned KEY_COUNT = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,

	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [1:0]  operation,
	input  wire logic [2:0]  keys_down,

	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [2:0]  event_kind,
	output      logic [2:0]  event_keys,
	output      logic        event_posted,
	output      logic        scan_active
);

	localparam int unsigned KW = keg_pkg::KEY_W;
	localparam int unsigned CW = keg_pkg::CNT_W;
	localparam logic [KW-1:0] KEYS_USED = (KEY_COUNT >= KW) ? {KW{1'b1}} :
		KW'((1 << KEY_COUNT) - 1);

	// timing registers
	logic [CW-1:0] press_q, long_q, repeat_q, release_q;

	// generator state
	logic [CW-1:0]      hold_q, rel_q;
	logic [KW-1:0]      held_q, slot_keys_q;
	keg_pkg::kind_t     slot_kind_q;
	logic               scan_q;

	// next state
	logic [CW-1:0]      hold_d, rel_d, hold_tmp;
	logic [KW-1:0]      held_d, slot_keys_d, keys;
	keg_pkg::kind_t     slot_kind_d;
	logic               scan_d;
	keg_pkg::result_t   res;

	// output register and skid entry
	keg_pkg::result_t   out_q, skid_q;
	logic               out_valid_q, skid_valid_q;

	logic in_xfer, out_xfer;

	assign in_stall = skid_valid_q;
	assign in_xfer  = in_valid && !skid_valid_q;
	assign out_xfer = out_valid_q && !out_stall;
	assign keys     = keys_down & KEYS_USED;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_q   <= keg_pkg::PRESS_RST;
			long_q    <= keg_pkg::LONG_RST;
			repeat_q  <= keg_pkg::REPEAT_RST;
			release_q <= keg_pkg::RELEASE_RST;
		end else if (cfg_we) begin
			unique case (keg_pkg::reg_idx_t'(cfg_index))
				keg_pkg::REG_PRESS:   press_q   <= cfg_data;
				keg_pkg::REG_LONG:    long_q    <= cfg_data;
				keg_pkg::REG_REPEAT:  repeat_q  <= cfg_data;
				keg_pkg::REG_RELEASE: release_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		hold_d      = hold_q;
		rel_d       = rel_q;
		held_d      = held_q;
		slot_kind_d = slot_kind_q;
		slot_keys_d = slot_keys_q;
		scan_d      = scan_q;
		hold_tmp    = hold_q;
		res.kind    = slot_kind_q;
		res.keys    = slot_keys_q;
		res.posted  = 1'b0;
		res.scan    = 1'b0;

		case (keg_pkg::op_t'(operation))
			keg_pkg::OP_TICK: begin
				if (keys != '0)
					scan_d = 1'b1;
				if (slot_kind_q == keg_pkg::KIND_NONE) begin
					if (keys == '0) begin
						if (held_q == '0) begin
							hold_d = '0;
							scan_d = 1'b0;
						end else if (hold_q > press_q) begin
							rel_d = (rel_q < keg_pkg::REL_MAX) ? rel_q + 1'b1 : rel_q;
							if (rel_d > release_q) begin
								if (hold_q != keg_pkg::HOLD_LOCKED) begin
									slot_kind_d = keg_pkg::KIND_RELEASED;
									slot_keys_d = held_q;
									res.posted  = 1'b1;
								end
								hold_d = '0;
								held_d = '0;
								rel_d  = '0;
								scan_d = 1'b0;
							end
						end else begin
							hold_d = '0;
							held_d = '0;
							rel_d  = '0;
							scan_d = 1'b0;
						end
					end else begin
						rel_d = '0;
						if (hold_q != keg_pkg::HOLD_LOCKED) begin
							if ((keys & ~held_q) != '0) begin
								// new key joined the set
								held_d = held_q | keys;
								if (hold_q == '0) begin
									slot_kind_d = keg_pkg::KIND_TOUCH;
									slot_keys_d = held_d;
									res.posted  = 1'b1;
								end else if (hold_q > long_q) begin
									slot_kind_d = keg_pkg::KIND_LONG;
									slot_keys_d = held_d;
									res.posted  = 1'b1;
								end
							end else begin
								if (hold_q == press_q) begin
									slot_kind_d = keg_pkg::KIND_PRESSED;
									slot_keys_d = held_q;
									res.posted  = 1'b1;
								end else if (hold_q == long_q) begin
									slot_kind_d = keg_pkg::KIND_LONG;
									slot_keys_d = held_q;
									res.posted  = 1'b1;
								end else if (hold_q == repeat_q) begin
									slot_kind_d = keg_pkg::KIND_REPEAT;
									slot_keys_d = held_q;
									res.posted  = 1'b1;
									hold_tmp    = long_q;
								end
								hold_d = (hold_tmp < keg_pkg::HOLD_MAX) ?
									hold_tmp + 1'b1 : hold_tmp;
							end
						end
					end
				end
				res.kind = slot_kind_d;
				res.keys = slot_keys_d;
			end
			keg_pkg::OP_READ: begin
				slot_kind_d = keg_pkg::KIND_NONE;
				slot_keys_d = '0;
			end
			keg_pkg::OP_FUNC: begin
				res.kind = keg_pkg::KIND_FIRST;
				res.keys = '0;
				if (hold_q != '0)
					hold_d = keg_pkg::HOLD_LOCKED;
			end
			default: ;
		endcase

		res.scan = scan_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q      <= '0;
			rel_q       <= '0;
			held_q      <= '0;
			slot_kind_q <= keg_pkg::KIND_NONE;
			slot_keys_q <= '0;
			scan_q      <= 1'b0;
		end else if (in_xfer) begin
			hold_q      <= hold_d;
			rel_q       <= rel_d;
			held_q      <= held_d;
			slot_kind_q <= slot_kind_d;
			slot_keys_q <= slot_keys_d;
			scan_q      <= scan_d;
		end
	end

	// output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_xfer) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_xfer;
			end
		end else if (in_xfer) begin
			if (out_valid_q)
				skid_valid_q <= 1'b1;
			else
				out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_xfer) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (in_xfer)
				out_q <= res;
		end else if (in_xfer) begin
			if (out_valid_q)
				skid_q <= res;
			else
				out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_kind   = out_q.kind;
	assign event_keys   = out_q.keys;
	assign event_posted = out_q.posted;
	assign scan_active  = out_q.scan;

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a result with the output register empty");

	a_hold_needs_keys: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q != '0 |-> held_q != '0)
		else $error("hold counter running with an empty key set");

	a_posted_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.posted |->
			out_q.kind != keg_pkg::KIND_NONE && out_q.kind != keg_pkg::KIND_FIRST)
		else $error("posted flag on a result without a key event");
`endif

endmodule

`default_nettype wire

[dv/key_event_generator_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_event_generator_test
// Self-checking bench for the key event generator: key hold/release sequences
// with random content and noise go in over the valid/stall channel, and every
// result is checked against a cycle-free model of the event logic. Both sides
// idle in random bursts, and the timing registers are swept between phases.
// ----------------------------------------------------------------------------

module key_event_generator_test;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]                op;
		logic [keg_pkg::KEY_W-1:0] keys;
	} key_item_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [1:0]                cfg_index = 2'd0;
	logic [7:0]                cfg_data = 8'd0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [1:0]                operation = 2'd0;
	logic [keg_pkg::KEY_W-1:0] keys_down = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [2:0]                event_kind;
	logic [keg_pkg::KEY_W-1:0] event_keys;
	logic                      event_posted;
	logic                      scan_active;

	key_event_generator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.keys_down    (keys_down),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_kind   (event_kind),
		.event_keys   (event_keys),
		.event_posted (event_posted),
		.scan_active  (scan_active)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// timing registers as the block should hold them
	logic [keg_pkg::CNT_W-1:0] press_ticks   = keg_pkg::PRESS_RST;
	logic [keg_pkg::CNT_W-1:0] long_ticks    = keg_pkg::LONG_RST;
	logic [keg_pkg::CNT_W-1:0] repeat_ticks  = keg_pkg::REPEAT_RST;
	logic [keg_pkg::CNT_W-1:0] release_ticks = keg_pkg::RELEASE_RST;

	// event generator state
	logic [keg_pkg::CNT_W-1:0] hold_cnt  = '0;
	logic [keg_pkg::CNT_W-1:0] rel_cnt   = '0;
	logic [keg_pkg::KEY_W-1:0] held_keys = '0;
	keg_pkg::kind_t            slot_kind = keg_pkg::KIND_NONE;
	logic [keg_pkg::KEY_W-1:0] slot_keys = '0;
	logic                      scanning  = 1'b0;

	key_item_t        sample_q[$];
	keg_pkg::result_t events_due[$];
	key_item_t        next_item;

	logic idle_on = 1'b1;
	int   gap_left = 0;
	int   stall_left = 0;
	int   hold_left = 0;
	bit   holdoff_done = 1'b0;
	int   n_results = 0;
	int   n_errors = 0;

	function automatic logic post_event(keg_pkg::kind_t kind);
		slot_kind = kind;
		slot_keys = held_keys;
		return 1'b1;
	endfunction

	function automatic void clear_press();
		hold_cnt  = '0;
		held_keys = '0;
		rel_cnt   = '0;
		scanning  = 1'b0;
	endfunction

	function automatic keg_pkg::result_t next_key_event(logic [1:0] op,
			logic [keg_pkg::KEY_W-1:0] keys);
		keg_pkg::result_t r;
		logic             posted;
		posted = 1'b0;
		r.kind = slot_kind;
		r.keys = slot_keys;
		case (op)
			keg_pkg::OP_TICK: begin
				if (keys != '0)
					scanning = 1'b1;
				// a full slot blocks everything but the wake-up
				if (slot_kind == keg_pkg::KIND_NONE) begin
					if (keys == '0) begin
						if (held_keys == '0) begin
							hold_cnt = '0;
							scanning = 1'b0;
						end else if (hold_cnt > press_ticks) begin
							if (rel_cnt != keg_pkg::REL_MAX)
								rel_cnt++;
							if (rel_cnt > release_ticks) begin
								if (hold_cnt != keg_pkg::HOLD_LOCKED)
									posted = post_event(keg_pkg::KIND_RELEASED);
								clear_press();
							end
						end else begin
							clear_press();
						end
					end else begin
						rel_cnt = '0;
						if (hold_cnt != keg_pkg::HOLD_LOCKED) begin
							if ((keys & ~held_keys) != '0) begin
								held_keys = held_keys | keys;
								if (hold_cnt == '0)
									posted = post_event(keg_pkg::KIND_TOUCH);
								else if (hold_cnt > long_ticks)
									posted = post_event(keg_pkg::KIND_LONG);
							end else begin
								if (hold_cnt == press_ticks) begin
									posted = post_event(keg_pkg::KIND_PRESSED);
								end else if (hold_cnt == long_ticks) begin
									posted = post_event(keg_pkg::KIND_LONG);
								end else if (hold_cnt == repeat_ticks) begin
									posted = post_event(keg_pkg::KIND_REPEAT);
									hold_cnt = long_ticks;
								end
								if (hold_cnt < keg_pkg::HOLD_MAX)
									hold_cnt++;
							end
						end
					end
				end
				r.kind = slot_kind;
				r.keys = slot_keys;
			end
			keg_pkg::OP_READ: begin
				slot_kind = keg_pkg::KIND_NONE;
				slot_keys = '0;
			end
			keg_pkg::OP_FUNC: begin
				r.kind = keg_pkg::KIND_FIRST;
				r.keys = '0;
				if (hold_cnt != '0)
					hold_cnt = keg_pkg::HOLD_LOCKED;
			end
			default: ;
		endcase
		r.posted = posted;
		r.scan   = scanning;
		return r;
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		n_errors++;
		$display("%0t: %s mismatch, got %0d expected %0d", $realtime, field, got, want);
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			operation <= keg_pkg::OP_TICK;
			keys_down <= '0;
			gap_left  = 0;
		end else begin
			if (in_valid && !in_stall)
				events_due.push_back(next_key_event(operation, keys_down));
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 99) < 6) begin
					gap_left = int'($urandom_range(0, 16));
					in_valid <= 1'b0;
				end else if (sample_q.size() != 0) begin
					next_item = sample_q.pop_front();
					in_valid  <= 1'b1;
					operation <= next_item.op;
					keys_down <= next_item.keys;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and output stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				n_results++;
				if (events_due.size() == 0) begin
					report_mismatch("unexpected transfer, event_kind", int'(event_kind), 0);
				end else begin
					if (event_kind !== events_due[0].kind)
						report_mismatch("event_kind", int'(event_kind),
							int'(events_due[0].kind));
					if (event_keys !== events_due[0].keys)
						report_mismatch("event_keys", int'(event_keys),
							int'(events_due[0].keys));
					if (event_posted !== events_due[0].posted)
						report_mismatch("event_posted", int'(event_posted),
							int'(events_due[0].posted));
					if (scan_active !== events_due[0].scan)
						report_mismatch("scan_active", int'(scan_active),
							int'(events_due[0].scan));
					void'(events_due.pop_front());
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!holdoff_done && n_results >= 250 && sample_q.size() > 20) begin
				// long back-pressure so the block fills and stalls its input
				holdoff_done = 1'b1;
				hold_left = 150;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 99) < 8) begin
				stall_left = int'($urandom_range(0, 16));
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic add_item(logic [1:0] op, logic [keg_pkg::KEY_W-1:0] keys);
		key_item_t it;
		it.op   = op;
		it.keys = keys;
		sample_q.push_back(it);
	endtask

	task automatic maybe_read(int pct);
		if ($urandom_range(0, 99) < pct)
			add_item(keg_pkg::OP_READ, 3'($urandom_range(0, 7)));
	endtask

	task automatic hold_keys(logic [keg_pkg::KEY_W-1:0] k, int ticks, int read_pct,
			int func_pct);
		logic [keg_pkg::KEY_W-1:0] kk;
		int                        sel;
		for (int i = 0; i < ticks; i++) begin
			kk  = k;
			sel = $urandom_range(0, 99);
			if (sel < 8)
				kk = k | 3'($urandom_range(1, 7));
			else if (sel < 16 && (k & 3'($urandom_range(1, 7))) != '0)
				kk = k & 3'($urandom_range(1, 7));
			add_item(keg_pkg::OP_TICK, kk);
			if ($urandom_range(0, 99) < func_pct)
				add_item(keg_pkg::OP_FUNC, 3'($urandom_range(0, 7)));
			maybe_read(read_pct);
		end
	endtask

	task automatic release_keys(int ticks, int read_pct);
		for (int i = 0; i < ticks; i++) begin
			add_item(keg_pkg::OP_TICK, '0);
			maybe_read(read_pct);
		end
	endtask

	task automatic mixed_presses(int n, int hold_max, int rel_max);
		int target;
		int sel;
		target = sample_q.size() + n;
		while (sample_q.size() < target) begin
			sel = $urandom_range(0, 99);
			if (sel < 75) begin
				hold_keys(3'($urandom_range(1, 7)), int'($urandom_range(1, hold_max)), 75, 3);
				release_keys(int'($urandom_range(0, rel_max)), 75);
			end else if (sel < 90) begin
				// contact bounce
				hold_keys(3'($urandom_range(1, 7)), int'($urandom_range(1, 3)), 60, 0);
				release_keys(int'($urandom_range(1, 3)), 60);
			end else begin
				repeat ($urandom_range(1, 8)) begin
					if ($urandom_range(0, 9) == 0)
						add_item(OP_UNUSED, 3'($urandom_range(0, 7)));
					else
						add_item(2'($urandom_range(0, 2)), 3'($urandom_range(0, 7)));
				end
			end
		end
	endtask

	// checked between edges so the driver's updates have settled
	task automatic drain();
		while (sample_q.size() != 0 || in_valid || events_due.size() != 0)
			@(negedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(keg_pkg::reg_idx_t idx, logic [7:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		case (idx)
			keg_pkg::REG_PRESS:   press_ticks = v;
			keg_pkg::REG_LONG:    long_ticks = v;
			keg_pkg::REG_REPEAT:  repeat_ticks = v;
			keg_pkg::REG_RELEASE: release_ticks = v;
		endcase
	endtask

	task automatic set_timing(logic [7:0] p, logic [7:0] l, logic [7:0] r, logic [7:0] rel);
		write_reg(keg_pkg::REG_PRESS, p);
		write_reg(keg_pkg::REG_LONG, l);
		write_reg(keg_pkg::REG_REPEAT, r);
		write_reg(keg_pkg::REG_RELEASE, rel);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset timing
		add_item(keg_pkg::OP_READ, 3'b111);
		add_item(OP_UNUSED, 3'b000);
		add_item(keg_pkg::OP_TICK, 3'b000);
		add_item(keg_pkg::OP_FUNC, 3'b000);      // not held: no lock
		add_item(keg_pkg::OP_TICK, 3'b011);      // touch
		add_item(keg_pkg::OP_TICK, 3'b100);      // slot full, ignored
		add_item(OP_UNUSED, 3'b101);
		add_item(keg_pkg::OP_READ, 3'b000);
		add_item(keg_pkg::OP_READ, 3'b000);
		add_item(keg_pkg::OP_TICK, 3'b100);      // new key before counting: touch again
		add_item(keg_pkg::OP_READ, 3'b000);
		repeat (5) add_item(keg_pkg::OP_TICK, 3'b111);
		add_item(keg_pkg::OP_READ, 3'b000);
		add_item(keg_pkg::OP_FUNC, 3'b010);      // lock while held
		add_item(keg_pkg::OP_TICK, 3'b111);
		repeat (5) add_item(keg_pkg::OP_TICK, 3'b000);
		// long hold towards long and repeat events, then release
		hold_keys(3'b101, 125, 30, 0);
		release_keys(7, 100);
		drain();

		set_timing(8'd2, 8'd5, 8'd8, 8'd2);
		mixed_presses(40, 14, 5);
		drain();
		mixed_presses(40, 14, 5);
		drain();

		set_timing(8'd1, 8'd1, 8'd254, 8'd0);
		mixed_presses(60, 6, 3);
		drain();

		// repeat below press: hold counter runs up to saturation
		set_timing(8'd253, 8'd253, 8'd2, 8'd254);
		hold_keys(3'b010, 20, 90, 0);
		add_item(keg_pkg::OP_READ, 3'b000);
		release_keys(258, 0);
		add_item(keg_pkg::OP_READ, 3'b000);
		mixed_presses(20, 6, 4);
		drain();

		idle_on <= 1'b0;
		set_timing(8'd3, 8'd7, 8'd10, 8'd1);
		mixed_presses(60, 16, 4);
		drain();

		repeat (5) @(posedge clk);
		if (n_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

[key_event_generator.f]
hdl/keg_pkg.sv
hdl/key_event_generator.sv
dv/key_event_generator_test.sv
